// ----- rtl/asc2bin_pkg.sv -----
// shared constants and codes for the ascii number to binary converter
package asc2bin_pkg;

  localparam int VALUE_BITS = 32;
  localparam int HEX_LIMIT  = VALUE_BITS / 4;
  localparam int CNT_W      = $clog2(HEX_LIMIT + 2);
  localparam int ERR_W      = 3;
  localparam int BASE_W     = 5;
  localparam int PH_W       = 3;
  localparam int OUT_DATA_W = ((VALUE_BITS + ERR_W + 7) / 8) * 8;

  localparam logic [VALUE_BITS-1:0] VAL_MAX  = '1;
  localparam logic [VALUE_BITS-1:0] DEC_TOP  = VAL_MAX / 10;
  localparam logic [VALUE_BITS-1:0] DEC_REST = VAL_MAX - DEC_TOP * 10;
  localparam logic [VALUE_BITS-1:0] OCT_TOP  = VAL_MAX / 8;
  localparam logic [VALUE_BITS-1:0] OCT_REST = VAL_MAX - OCT_TOP * 8;

  // parse phases
  localparam logic [PH_W-1:0] PH_START     = 3'd0;
  localparam logic [PH_W-1:0] PH_ZERO_AUTO = 3'd1;
  localparam logic [PH_W-1:0] PH_ZERO_DEC  = 3'd2;
  localparam logic [PH_W-1:0] PH_ZERO_X    = 3'd3;
  localparam logic [PH_W-1:0] PH_HEX       = 3'd4;
  localparam logic [PH_W-1:0] PH_DEC       = 3'd5;
  localparam logic [PH_W-1:0] PH_OCT       = 3'd6;
  localparam logic [PH_W-1:0] PH_BADBASE   = 3'd7;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE   = 3'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY  = 3'd1;
  localparam logic [ERR_W-1:0] ERR_BASE   = 3'd2;
  localparam logic [ERR_W-1:0] ERR_HEXDIG = 3'd3;
  localparam logic [ERR_W-1:0] ERR_HEXLEN = 3'd4;
  localparam logic [ERR_W-1:0] ERR_DIGIT  = 3'd5;
  localparam logic [ERR_W-1:0] ERR_OVF    = 3'd6;

  // base register codes
  localparam logic [BASE_W-1:0] BASE_AUTO        = 5'd0;
  localparam logic [BASE_W-1:0] BASE_AUTO_NO_OCT = 5'd13;
  localparam logic [BASE_W-1:0] BASE_OCT         = 5'd8;
  localparam logic [BASE_W-1:0] BASE_DEC         = 5'd10;
  localparam logic [BASE_W-1:0] BASE_HEX         = 5'd16;

  // characters
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;

endpackage

// ----- rtl/ascii_number_to_binary.sv -----
// top level: streaming ascii number to 32-bit unsigned converter
// the result of an end-marker transfer passes the input register and then the
//   result register before it is on out_*
// throughput: one character or end marker per cycle; an end marker stalls only
//   while the result register is full and not being taken
// digit update (shift-add by 8, 10 or 16, limit compare for 8 and 10) sits between the
//   input register and the parse state / result register
// reset (rst_n low, synchronous) clears the parse state, both valids and the
//   base register (auto mode)
module ascii_number_to_binary (
  input  logic        clk,
  input  logic        rst_n,
  // character channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,   // is_end
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [asc2bin_pkg::OUT_DATA_W-1:0] out_tdata, // [31:0] value, [34:32] error_code, rest 0
  // base register write
  input  logic        cfg_we,
  input  logic [asc2bin_pkg::BASE_W-1:0] cfg_wdata  // number_base
);

  localparam int VB = asc2bin_pkg::VALUE_BITS;

  // base register
  logic [asc2bin_pkg::BASE_W-1:0] base_r;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_ch_r;
  logic       s1_last_r;
  logic       s1_advance;

  // parse state
  logic [asc2bin_pkg::PH_W-1:0]  phase_r, phase_nxt;
  logic [VB-1:0]                 acc_r, acc_nxt;
  logic [asc2bin_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [asc2bin_pkg::ERR_W-1:0] err_r, err_nxt;

  // result register
  logic                          out_valid_r, out_valid_nxt;
  logic [VB-1:0]                 out_value_r, out_value_nxt;
  logic [asc2bin_pkg::ERR_W-1:0] out_err_r, out_err_nxt;

  // digit decode
  logic       do_hex, do_dec, do_oct;
  logic       hex_ok;
  logic [3:0] hex_d;
  logic       dec_ok, oct_ok;
  logic [3:0] rad_d;
  logic       dec_ovf, oct_ovf;
  logic       is_x;
  logic       take_char, take_end;
  logic [asc2bin_pkg::ERR_W-1:0] end_err;

  // an end marker needs the result register free; characters never wait
  assign take_char  = s1_valid_r && !s1_last_r;
  assign s1_advance = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign take_end   = s1_valid_r && s1_last_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= asc2bin_pkg::BASE_AUTO;
    end else if (cfg_we) begin
      base_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_ch_r   <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // character classification
  always_comb begin
    hex_ok = 1'b1;
    hex_d  = 4'd0;
    if (s1_ch_r >= asc2bin_pkg::CH_0 && s1_ch_r <= asc2bin_pkg::CH_9) begin
      hex_d = 4'(s1_ch_r - asc2bin_pkg::CH_0);
    end else if (s1_ch_r >= asc2bin_pkg::CH_LO_A && s1_ch_r <= asc2bin_pkg::CH_LO_F) begin
      hex_d = 4'(s1_ch_r - asc2bin_pkg::CH_LO_A + 8'd10);
    end else if (s1_ch_r >= asc2bin_pkg::CH_UP_A && s1_ch_r <= asc2bin_pkg::CH_UP_F) begin
      hex_d = 4'(s1_ch_r - asc2bin_pkg::CH_UP_A + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign rad_d  = 4'(s1_ch_r - asc2bin_pkg::CH_0);
  assign dec_ok = (s1_ch_r >= asc2bin_pkg::CH_0) && (s1_ch_r <= asc2bin_pkg::CH_9);
  assign oct_ok = (s1_ch_r >= asc2bin_pkg::CH_0) && (s1_ch_r <= asc2bin_pkg::CH_7);
  assign is_x   = (s1_ch_r == asc2bin_pkg::CH_LO_X) || (s1_ch_r == asc2bin_pkg::CH_UP_X);

  // limit compare before the multiply-add would wrap
  assign dec_ovf = (acc_r > asc2bin_pkg::DEC_TOP) ||
                   ((acc_r == asc2bin_pkg::DEC_TOP) && ({{(VB-4){1'b0}}, rad_d} > asc2bin_pkg::DEC_REST));
  assign oct_ovf = (acc_r > asc2bin_pkg::OCT_TOP) ||
                   ((acc_r == asc2bin_pkg::OCT_TOP) && ({{(VB-4){1'b0}}, rad_d} > asc2bin_pkg::OCT_REST));

  // end-of-string error selection; a latched error always wins
  always_comb begin
    end_err = err_r;
    if (err_r == asc2bin_pkg::ERR_NONE) begin
      priority if (phase_r == asc2bin_pkg::PH_START) begin
        end_err = asc2bin_pkg::ERR_EMPTY;
      end else if (phase_r == asc2bin_pkg::PH_ZERO_X) begin
        end_err = asc2bin_pkg::ERR_DIGIT;  // lone "0x"
      end else if (phase_r == asc2bin_pkg::PH_BADBASE) begin
        end_err = asc2bin_pkg::ERR_BASE;
      end else if (phase_r == asc2bin_pkg::PH_HEX &&
                   cnt_r > asc2bin_pkg::CNT_W'(asc2bin_pkg::HEX_LIMIT)) begin
        end_err = asc2bin_pkg::ERR_HEXLEN;
      end else begin
        end_err = asc2bin_pkg::ERR_NONE;
      end
    end
  end

  // per-character phase step
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    do_hex    = 1'b0;
    do_dec    = 1'b0;
    do_oct    = 1'b0;

    if (take_char && err_r == asc2bin_pkg::ERR_NONE) begin
      unique case (phase_r)
        asc2bin_pkg::PH_START: begin
          // base is sampled at the first character of a string
          if (base_r == asc2bin_pkg::BASE_AUTO || base_r == asc2bin_pkg::BASE_AUTO_NO_OCT) begin
            if (s1_ch_r == asc2bin_pkg::CH_0) begin
              phase_nxt = (base_r == asc2bin_pkg::BASE_AUTO) ? asc2bin_pkg::PH_ZERO_AUTO
                                                             : asc2bin_pkg::PH_ZERO_DEC;
            end else begin
              phase_nxt = asc2bin_pkg::PH_DEC;
              do_dec    = 1'b1;
            end
          end else if (base_r == asc2bin_pkg::BASE_OCT) begin
            phase_nxt = asc2bin_pkg::PH_OCT;
            do_oct    = 1'b1;
          end else if (base_r == asc2bin_pkg::BASE_DEC) begin
            phase_nxt = asc2bin_pkg::PH_DEC;
            do_dec    = 1'b1;
          end else if (base_r == asc2bin_pkg::BASE_HEX) begin
            phase_nxt = asc2bin_pkg::PH_HEX;
            do_hex    = 1'b1;
          end else begin
            phase_nxt = asc2bin_pkg::PH_BADBASE;
            err_nxt   = asc2bin_pkg::ERR_BASE;
          end
        end
        asc2bin_pkg::PH_ZERO_AUTO: begin
          if (is_x) begin
            phase_nxt = asc2bin_pkg::PH_ZERO_X;
          end else begin
            phase_nxt = asc2bin_pkg::PH_OCT;
            do_oct    = 1'b1;
          end
        end
        asc2bin_pkg::PH_ZERO_DEC: begin
          if (is_x) begin
            phase_nxt = asc2bin_pkg::PH_ZERO_X;
          end else begin
            phase_nxt = asc2bin_pkg::PH_DEC;
            do_dec    = 1'b1;
          end
        end
        asc2bin_pkg::PH_ZERO_X: begin
          phase_nxt = asc2bin_pkg::PH_HEX;
          do_hex    = 1'b1;
        end
        asc2bin_pkg::PH_HEX:     do_hex = 1'b1;
        asc2bin_pkg::PH_DEC:     do_dec = 1'b1;
        asc2bin_pkg::PH_OCT:     do_oct = 1'b1;
        asc2bin_pkg::PH_BADBASE: ;
        default: ;
      endcase

      if (do_hex) begin
        if (!hex_ok) begin
          err_nxt = asc2bin_pkg::ERR_HEXDIG;
        end else begin
          // hex wraps; length is checked only at the end
          acc_nxt = {acc_r[VB-5:0], hex_d};
          if (cnt_r <= asc2bin_pkg::CNT_W'(asc2bin_pkg::HEX_LIMIT)) begin
            cnt_nxt = cnt_r + asc2bin_pkg::CNT_W'(1);
          end
        end
      end else if (do_dec) begin
        if (!dec_ok) begin
          err_nxt = asc2bin_pkg::ERR_DIGIT;
        end else if (dec_ovf) begin
          err_nxt = asc2bin_pkg::ERR_OVF;
        end else begin
          // times ten as two shifts
          acc_nxt = (acc_r << 3) + (acc_r << 1) + {{(VB-4){1'b0}}, rad_d};
        end
      end else if (do_oct) begin
        if (!oct_ok) begin
          err_nxt = asc2bin_pkg::ERR_DIGIT;
        end else if (oct_ovf) begin
          err_nxt = asc2bin_pkg::ERR_OVF;
        end else begin
          acc_nxt = {acc_r[VB-4:0], rad_d[2:0]};
        end
      end
    end

    // end marker closes the string and clears the parse state
    if (take_end) begin
      phase_nxt = asc2bin_pkg::PH_START;
      acc_nxt   = '0;
      cnt_nxt   = '0;
      err_nxt   = asc2bin_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= asc2bin_pkg::PH_START;
      acc_r   <= '0;
      cnt_r   <= '0;
      err_r   <= asc2bin_pkg::ERR_NONE;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_err_nxt   = out_err_r;
    if (take_end) begin
      out_valid_nxt = 1'b1;
      out_err_nxt   = end_err;
      out_value_nxt = (end_err == asc2bin_pkg::ERR_NONE) ? acc_r : '0;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(asc2bin_pkg::OUT_DATA_W - VB - asc2bin_pkg::ERR_W){1'b0}},
                       out_err_r, out_value_r};

endmodule

// ----- rtl/asc2bin_checker.sv -----
// port-level checks for the ascii number to binary converter, bound to the top level
module asc2bin_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [asc2bin_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int VB = asc2bin_pkg::VALUE_BITS;

  // result register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // error codes stay within the defined set and padding stays zero
  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[VB+asc2bin_pkg::ERR_W-1:VB] <= asc2bin_pkg::ERR_OVF) &&
                   (out_tdata[asc2bin_pkg::OUT_DATA_W-1:VB+asc2bin_pkg::ERR_W] == '0))
    else $error("bad error code or padding");

  // a failed conversion carries a zero value
  a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[VB+asc2bin_pkg::ERR_W-1:VB] != asc2bin_pkg::ERR_NONE)
      |-> (out_tdata[VB-1:0] == '0))
    else $error("value not zero on error");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed while stalled");

endmodule

bind ascii_number_to_binary asc2bin_checker u_asc2bin_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- verif/ascii_number_to_binary_test.sv -----
// self-checking testbench for the streaming ascii number to binary converter
module ascii_number_to_binary_test;
  timeunit 1ns;
  timeprecision 1ps;

  import asc2bin_pkg::*;

  // base register value outside every supported mode, all bits set
  localparam logic [BASE_W-1:0] BASE_UNSUPPORTED = 5'd31;
  // widest value that decimal and octal digits may build up to
  localparam logic [63:0] VALUE_LIMIT = 64'h0000_0000_FFFF_FFFF;
  // margin for the result register to drain after the end marker
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 800;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [ERR_W-1:0]      code;
  } conv_result_t;

  // predicts each conversion from the characters seen and checks results in order
  class conv_scoreboard;
    logic [BASE_W-1:0] base;
    logic [PH_W-1:0]   phase;
    logic [63:0]       acc;
    int unsigned       hex_digits;
    logic [ERR_W-1:0]  err;
    conv_result_t      expected_q[$];
    int unsigned       mismatches;

    function new();
      base = BASE_AUTO;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      phase = PH_START;
      acc = '0;
      hex_digits = 0;
      err = ERR_NONE;
    endfunction

    function void set_base(logic [BASE_W-1:0] b);
      base = b;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void take_hex(logic [7:0] c);
      logic [3:0] d;
      if (c >= CH_0 && c <= CH_9) begin
        d = 4'(c - CH_0);
      end else if (c >= CH_LO_A && c <= CH_LO_F) begin
        d = 4'(c - CH_LO_A + 8'd10);
      end else if (c >= CH_UP_A && c <= CH_UP_F) begin
        d = 4'(c - CH_UP_A + 8'd10);
      end else begin
        err = ERR_HEXDIG;
        return;
      end
      // hex wraps, only the digit count catches a long string
      acc = ((acc << 4) | 64'(d)) & VALUE_LIMIT;
      if (hex_digits <= HEX_LIMIT) hex_digits++;
    endfunction

    function void take_radix(logic [7:0] c, int unsigned radix);
      logic [63:0] grown;
      if (c < CH_0 || 32'(c) >= 32'(CH_0) + radix) begin
        err = ERR_DIGIT;
        return;
      end
      grown = acc * 64'(radix) + 64'(c - CH_0);
      if (grown > VALUE_LIMIT) err = ERR_OVF;
      else acc = grown;
    endfunction

    function void note_input(logic [7:0] c, logic last);
      conv_result_t r;
      if (last) begin
        r.code = err;
        if (r.code == ERR_NONE) begin
          if (phase == PH_START) r.code = ERR_EMPTY;
          else if (phase == PH_ZERO_X) r.code = ERR_DIGIT;
          else if (phase == PH_BADBASE) r.code = ERR_BASE;
          else if (phase == PH_HEX && hex_digits > HEX_LIMIT) r.code = ERR_HEXLEN;
        end
        r.value = (r.code == ERR_NONE) ? acc[VALUE_BITS-1:0] : '0;
        expected_q.push_back(r);
        restart();
      end else if (err == ERR_NONE) begin
        case (phase)
          PH_START: begin
            if (base == BASE_AUTO || base == BASE_AUTO_NO_OCT) begin
              if (c == CH_0) begin
                phase = (base == BASE_AUTO) ? PH_ZERO_AUTO : PH_ZERO_DEC;
              end else begin
                phase = PH_DEC;
                take_radix(c, 10);
              end
            end else if (base == BASE_OCT) begin
              phase = PH_OCT;
              take_radix(c, 8);
            end else if (base == BASE_DEC) begin
              phase = PH_DEC;
              take_radix(c, 10);
            end else if (base == BASE_HEX) begin
              phase = PH_HEX;
              take_hex(c);
            end else begin
              phase = PH_BADBASE;
              err = ERR_BASE;
            end
          end
          PH_ZERO_AUTO: begin
            if (c == CH_LO_X || c == CH_UP_X) begin
              phase = PH_ZERO_X;
            end else begin
              phase = PH_OCT;
              take_radix(c, 8);
            end
          end
          PH_ZERO_DEC: begin
            if (c == CH_LO_X || c == CH_UP_X) begin
              phase = PH_ZERO_X;
            end else begin
              phase = PH_DEC;
              take_radix(c, 10);
            end
          end
          PH_ZERO_X: begin
            phase = PH_HEX;
            take_hex(c);
          end
          PH_HEX: take_hex(c);
          PH_DEC: take_radix(c, 10);
          PH_OCT: take_radix(c, 8);
          default: ;
        endcase
      end
    endfunction

    function void check_result(logic [VALUE_BITS-1:0] value, logic [ERR_W-1:0] code);
      conv_result_t e;
      if (expected_q.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("unexpected result: value %h code %0d", value, code);
        mismatches++;
        return;
      end
      e = expected_q.pop_front();
      if (value !== e.value || code !== e.code) begin
        if (mismatches < REPORT_LIMIT)
          $display("mismatch: expected value %h code %0d, got value %h code %0d",
                   e.value, e.code, value, code);
        mismatches++;
      end
    endfunction
  endclass

  // every input known from time zero
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [BASE_W-1:0] cfg_wdata = BASE_AUTO;

  conv_scoreboard sb = new();

  // idling knobs, changed by the stimulus between phases
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  // long receiver hold-offs: asked for by the stimulus, served by the receiver
  int unsigned holds_asked = 0;
  int unsigned holds_served = 0;
  int unsigned items_sent = 0;
  logic [7:0] chars_q[$];

  ascii_number_to_binary dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // both channels are observed at the rising edge, before any update of that edge lands
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[VALUE_BITS-1:0], out_tdata[VALUE_BITS+ERR_W-1:VALUE_BITS]);
  end

  // receiver: random stalls, and now and then a long hold-off so the block backs up
  initial begin
    forever begin
      @(posedge clk);
      if (holds_asked != holds_served) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served++;
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // one transfer on the character channel, with random idle cycles in front
  task automatic send_item(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // drain the character queue, then close the string; the end marker carries junk in ch
  task automatic send_queued();
    while (chars_q.size() != 0) send_item(chars_q.pop_front(), 1'b0);
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) chars_q.push_back(s[i]);
  endfunction

  // base register is only touched with nothing in flight
  task automatic settle_and_set_base(input logic [BASE_W-1:0] b);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_base(b);
  endtask

  // mostly well-formed numbers for the current base, with some noise and damage
  function automatic void queue_random_number(logic [BASE_W-1:0] b);
    logic [63:0] v;
    int unsigned radix;
    int unsigned style;
    int unsigned d;
    int unsigned pick;
    bit upper;
    style = $urandom_range(99);
    chars_q.delete();
    // empty string
    if (style < 6) return;
    // raw bytes, anything from nul to 0xff
    if (style < 12) begin
      repeat ($urandom_range(6, 1)) chars_q.push_back(8'($urandom_range(255)));
      return;
    end
    // lone zero, or a prefix with nothing after it
    if (style < 15) begin
      chars_q.push_back(CH_0);
      if (style != 12) chars_q.push_back((style == 13) ? CH_LO_X : CH_UP_X);
      return;
    end
    case (b)
      BASE_HEX: radix = 16;
      BASE_OCT: radix = 8;
      BASE_AUTO: begin
        pick = $urandom_range(2);
        radix = (pick == 0) ? 10 : (pick == 1) ? 8 : 16;
      end
      BASE_AUTO_NO_OCT: radix = ($urandom_range(1) == 1) ? 16 : 10;
      default: radix = 10;
    endcase
    // largest value, one past it, full 64-bit range, or mostly moderate sizes
    pick = $urandom_range(9);
    if (pick == 0) v = VALUE_LIMIT;
    else if (pick == 1) v = VALUE_LIMIT + 64'd1;
    else if (pick == 2) v = {$urandom, $urandom};
    else v = {$urandom, $urandom} >> $urandom_range(63, 28);
    upper = 1'($urandom_range(1));
    do begin
      d = 32'(v % 64'(radix));
      if (d < 10) chars_q.push_front(CH_0 + 8'(d));
      else chars_q.push_front((upper ? CH_UP_A : CH_LO_A) + 8'(d - 10));
      v = v / 64'(radix);
    end while (v != 0);
    if ($urandom_range(9) == 0) chars_q.push_front(CH_0);
    if (b == BASE_AUTO || b == BASE_AUTO_NO_OCT) begin
      if (radix == 16) begin
        chars_q.push_front($urandom_range(1) ? CH_UP_X : CH_LO_X);
        chars_q.push_front(CH_0);
      end else if (radix == 8) begin
        chars_q.push_front(CH_0);
      end
    end
    // damage one character now and then
    if ($urandom_range(9) < 2)
      chars_q[$urandom_range(chars_q.size() - 1)] = 8'($urandom_range(255));
  endfunction

  // stimulus
  initial begin
    int unsigned phase_no;
    int unsigned phase_end;
    int unsigned random_start;
    logic [BASE_W-1:0] b;
    logic [BASE_W-1:0] base_tab[6];
    int unsigned idle_tab[4];
    int unsigned stall_tab[4];
    base_tab = '{BASE_AUTO, BASE_HEX, BASE_DEC, BASE_OCT, BASE_AUTO_NO_OCT, BASE_UNSUPPORTED};
    // no idling, sender idle, receiver stalling, both
    idle_tab = '{0, 51, 0, 22};
    stall_tab = '{0, 0, 51, 22};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, auto mode straight out of reset
    send_queued();                      // empty string
    push_text("0");
    send_queued();                      // single zero is decimal zero
    push_text("0x");
    send_queued();                      // prefix alone: x is a bad digit
    push_text("0Xf");
    send_queued();                      // upper-case prefix selects hex
    push_text("07");
    send_queued();                      // leading zero selects octal
    chars_q.push_back(8'h00);
    send_queued();                      // nul outside hex is a bad digit
    chars_q.push_back(8'hff);
    send_queued();                      // non-ascii byte
    settle_and_set_base(BASE_HEX);
    chars_q.push_back(8'h00);
    send_queued();                      // nul in hex is a bad hex digit
    settle_and_set_base(BASE_UNSUPPORTED);
    push_text("1");
    send_queued();                      // unsupported base
    send_queued();                      // empty beats unsupported base
    settle_and_set_base(BASE_AUTO_NO_OCT);
    push_text("07");
    send_queued();                      // leading zero stays decimal here

    // random part in phases, each with its own base and idling pattern
    random_start = items_sent;
    phase_no = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      b = (phase_no % 7 == 6) ? BASE_W'($urandom_range(31)) : base_tab[phase_no % 7];
      settle_and_set_base(b);
      idle_pct = idle_tab[phase_no % 4];
      stall_pct = stall_tab[phase_no % 4];
      // long hold-off while the sender keeps offering, so the input stalls
      if (phase_no % 5 == 0) holds_asked++;
      // unsupported bases ignore most characters, keep those phases short
      if (b == BASE_AUTO || b == BASE_AUTO_NO_OCT || b == BASE_OCT ||
          b == BASE_DEC || b == BASE_HEX) begin
        phase_end = items_sent + 90;
      end else begin
        phase_end = items_sent + 25;
      end
      while (items_sent < phase_end) begin
        queue_random_number(b);
        send_queued();
      end
      phase_no++;
    end

    // drain, then give any stray result time to show up
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/asc2bin_pkg.sv
rtl/ascii_number_to_binary.sv
rtl/asc2bin_checker.sv
verif/ascii_number_to_binary_test.sv
